// ===== rtl/telemetry_frame_builder_assert.svh =====
// ----------------------------------------------------------------------------
// Telemetry frame builder assertion macros
// Shorthand for the concurrent checks used on the frame builder ports.
// ----------------------------------------------------------------------------
`ifndef TELEMETRY_FRAME_BUILDER_ASSERT_SVH
`define TELEMETRY_FRAME_BUILDER_ASSERT_SVH

// Same-cycle implication, ignored while reset is held
`define TFB_AST_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tfb check failed");

// Next-cycle implication, ignored while reset is held
`define TFB_AST_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tfb check failed");

// Next-cycle implication that also covers the reset cycles
`define TFB_AST_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("tfb check failed");

`endif

// ===== rtl/tfb_pkg.sv =====
// ----------------------------------------------------------------------------
// Telemetry frame builder package
// Frame kinds, byte constants and the payload layout of each kind.
// ----------------------------------------------------------------------------
package tfb_pkg;

    localparam logic [7:0] SYNC_BYTE   = 8'hAA;
    localparam logic [7:0] STATUS_TAIL = 8'hA1;
    localparam logic [7:0] ID_STATUS   = 8'h01;
    localparam logic [7:0] ID_SENSOR   = 8'h02;
    localparam logic [7:0] ID_RC       = 8'h03;
    localparam logic [7:0] ID_MOTOR    = 8'h06;

    localparam int unsigned NUM_WORDS = 6;
    localparam int unsigned WORD_W    = 16;
    localparam int unsigned IDX_W     = 5;   // byte position 0..24

    // Byte positions in the frame header
    localparam logic [IDX_W-1:0] POS_SYNC1 = 5'd1;
    localparam logic [IDX_W-1:0] POS_ID    = 5'd2;
    localparam logic [IDX_W-1:0] POS_LEN   = 5'd3;
    localparam logic [IDX_W-1:0] POS_PAYLD = 5'd4;

    typedef enum logic [1:0] {
        CMD_STATUS = 2'd0,
        CMD_SENSOR = 2'd1,
        CMD_RC     = 2'd2,
        CMD_MOTOR  = 2'd3
    } t_cmd;

    typedef logic [NUM_WORDS-1:0][WORD_W-1:0] t_words;

    // Current byte offered by the sequencer
    typedef struct packed {
        logic       busy;
        logic [7:0] data;
        logic       last;
    } t_seq_status;

    // Function id of each kind
    function automatic logic [7:0] frame_id(input t_cmd cmd);
        logic [7:0] id;
        case (cmd)
            CMD_STATUS: id = ID_STATUS;
            CMD_SENSOR: id = ID_SENSOR;
            CMD_RC:     id = ID_RC;
            CMD_MOTOR:  id = ID_MOTOR;
            default:    id = ID_MOTOR;
        endcase
        return id;
    endfunction

    // Payload length byte of each kind
    function automatic logic [7:0] payload_len(input t_cmd cmd);
        logic [7:0] len;
        case (cmd)
            CMD_STATUS: len = 8'd13;
            CMD_SENSOR: len = 8'd18;
            CMD_RC:     len = 8'd20;
            CMD_MOTOR:  len = 8'd16;
            default:    len = 8'd16;
        endcase
        return len;
    endfunction

    // Position of the checksum byte: payload length plus four header bytes
    function automatic logic [IDX_W-1:0] last_pos(input t_cmd cmd);
        logic [7:0] len;
        len = payload_len(cmd) + 8'd4;
        return len[IDX_W-1:0];
    endfunction

    // Byte k of the packed word sequence, high byte of each word first
    function automatic logic [7:0] word_byte(input t_words words, input logic [3:0] k);
        logic [WORD_W-1:0] w;
        w = words[k[3:1]];
        return k[0] ? w[7:0] : w[15:8];
    endfunction

    // Payload byte q (position minus four) of a frame of the given kind
    function automatic logic [7:0] payload_byte(input t_cmd cmd, input t_words words,
                                                input logic [IDX_W-1:0] q);
        logic [7:0]       b;
        logic [IDX_W-1:0] qs;
        qs = q - 5'd6;
        b  = 8'h00;
        case (cmd)
            CMD_STATUS: begin
                if (q < 5'd6) begin
                    b = word_byte(words, q[3:0]);
                end else if (q == 5'd12) begin
                    b = STATUS_TAIL;
                end
            end
            CMD_SENSOR: begin
                if (q >= 5'd6 && q < 5'd12) begin
                    b = word_byte(words, qs[3:0]);
                end
            end
            CMD_RC: begin
                if (q < 5'd12) begin
                    b = word_byte(words, q[3:0]);
                end
            end
            CMD_MOTOR: begin
                if (q < 5'd8) begin
                    b = word_byte(words, q[3:0]);
                end
            end
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ===== rtl/tfb_frame_seq.sv =====
// ----------------------------------------------------------------------------
// Telemetry frame sequencer
// Holds one frame request and walks its bytes, keeping the running checksum.
// ----------------------------------------------------------------------------
module tfb_frame_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  tfb_pkg::t_cmd       i_cmd,
    input  tfb_pkg::t_words     i_words,
    input  logic                i_step,
    output tfb_pkg::t_seq_status o_status
);

    logic                         r_busy, n_busy;
    logic [tfb_pkg::IDX_W-1:0]    r_idx,  n_idx;
    logic [7:0]                   r_sum,  n_sum;
    tfb_pkg::t_cmd                r_cmd;
    tfb_pkg::t_words              r_words;

    logic [7:0]                   w_data;
    logic                         w_last;
    logic [tfb_pkg::IDX_W-1:0]    w_q;

    // Byte at the current position
    always_comb begin
        w_q    = r_idx - tfb_pkg::POS_PAYLD;
        w_last = (r_idx == tfb_pkg::last_pos(r_cmd));
        if (r_idx <= tfb_pkg::POS_SYNC1) begin
            w_data = tfb_pkg::SYNC_BYTE;
        end else if (r_idx == tfb_pkg::POS_ID) begin
            w_data = tfb_pkg::frame_id(r_cmd);
        end else if (r_idx == tfb_pkg::POS_LEN) begin
            w_data = tfb_pkg::payload_len(r_cmd);
        end else if (w_last) begin
            w_data = r_sum;
        end else begin
            w_data = tfb_pkg::payload_byte(r_cmd, r_words, w_q);
        end
    end

    // Load a request or advance one byte
    always_comb begin
        n_busy = r_busy;
        n_idx  = r_idx;
        n_sum  = r_sum;
        if (i_load) begin
            n_busy = 1'b1;
            n_idx  = '0;
            n_sum  = '0;
        end else if (i_step) begin
            n_busy = !w_last;
            n_idx  = r_idx + 5'd1;
            n_sum  = r_sum + w_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
            r_sum  <= '0;
        end else begin
            r_busy <= n_busy;
            r_idx  <= n_idx;
            r_sum  <= n_sum;
        end
    end

    // Request payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_cmd   <= i_cmd;
            r_words <= i_words;
        end
    end

    assign o_status.busy = r_busy;
    assign o_status.data = w_data;
    assign o_status.last = w_last;

endmodule

// ===== rtl/telemetry_frame_builder.sv =====
// ----------------------------------------------------------------------------
// Telemetry frame builder
// Turns one frame request into a serial byte frame with sync, id, length,
// payload and an additive checksum.
// ----------------------------------------------------------------------------
// Each request on the slave side becomes one frame on the master side, one
// byte per transaction: 18 bytes for status, 23 for sensor, 21 for motor and
// 25 for rc, with tlast on the closing checksum byte. Bytes leave at one per
// cycle while m_tready stays high, through a single output register; the
// next request is taken in the cycle in which the last byte of the current
// frame moves into the output register, and frames follow each other with
// no gap. No state survives between requests.
module telemetry_frame_builder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // word0, word1, word2, word3, word4, word5
    input  logic [1:0]  s_tuser,   // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // frame_byte
    output logic        m_tlast
);

    tfb_pkg::t_seq_status w_seq;
    logic                 w_step;
    logic                 w_load;

    logic                 r_m_valid, n_m_valid;
    logic [7:0]           r_m_data;
    logic                 r_m_last;

    // Advance when the output register is free or being emptied
    assign w_step   = w_seq.busy && (!r_m_valid || m_tready);
    assign s_tready = !w_seq.busy || (w_step && w_seq.last);
    assign w_load   = s_tvalid && s_tready;

    tfb_frame_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_load),
        .i_cmd    (tfb_pkg::t_cmd'(s_tuser)),
        .i_words  (tfb_pkg::t_words'(s_tdata)),
        .i_step   (w_step),
        .o_status (w_seq)
    );

    // Output register valid
    always_comb begin
        n_m_valid = r_m_valid;
        if (w_step) begin
            n_m_valid = 1'b1;
        end else if (m_tready) begin
            n_m_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else begin
            r_m_valid <= n_m_valid;
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_m_data <= w_seq.data;
            r_m_last <= w_seq.last;
        end
    end

    assign m_tvalid = r_m_valid;
    assign m_tdata  = r_m_data;
    assign m_tlast  = r_m_last;

endmodule

// ===== rtl/tfb_checker.sv =====
// ----------------------------------------------------------------------------
// Telemetry frame builder checker
// Port-level checks on framing and the output handshake.
// ----------------------------------------------------------------------------
`include "telemetry_frame_builder_assert.svh"

module tfb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic        m_tlast
);

    // Set at the start of every frame: after reset and after a tlast transaction
    logic r_frame_start, n_frame_start;

    always_comb begin
        n_frame_start = r_frame_start;
        if (m_tvalid && m_tready) begin
            n_frame_start = m_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_start <= 1'b1;
        end else begin
            r_frame_start <= n_frame_start;
        end
    end

    // First byte of each frame is a sync byte and cannot end the frame
    `TFB_AST_IMPLY(a_frame_sync, i_clk, i_rst_n, m_tvalid && r_frame_start,
                   m_tdata == tfb_pkg::SYNC_BYTE && !m_tlast)

    // Busy input side means a byte is on offer by the next cycle
    `TFB_AST_NEXT(a_busy_output, i_clk, i_rst_n, !s_tready, m_tvalid)

    // Stalled output holds
    `TFB_AST_NEXT(a_out_hold, i_clk, i_rst_n, m_tvalid && !m_tready,
                  m_tvalid && $stable(m_tdata) && $stable(m_tlast))

    // Nothing on offer straight after reset
    `TFB_AST_NEXT_ALWAYS(a_reset_idle, i_clk, !i_rst_n, !m_tvalid)

endmodule

bind telemetry_frame_builder tfb_checker u_tfb_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
